// ----- src/lvcmc_pkg.sv -----
// ----------------------------------------------------------------------------
// lvcmc_pkg
// Shared constants and types for the LRU vertex cache miss counter.
// ----------------------------------------------------------------------------
package lvcmc_pkg;

  // Built cache depth (number of cells in the chain)
  localparam int MAX_ENTRIES = 32;

  localparam int VERTEX_W = 32;
  localparam int CFG_W    = 6;
  localparam int MISS_W   = 32;
  localparam int INDEX_W  = 32;
  localparam int TRI_W    = 31;

  // Width that holds any size value, configured or built
  localparam int SIZE_W = $clog2(MAX_ENTRIES + 1);
  localparam int CMP_W  = (SIZE_W > CFG_W) ? SIZE_W : CFG_W;

  localparam logic [CFG_W-1:0] CACHE_SIZE_RESET = CFG_W'(32);

  localparam logic [MISS_W-1:0]  MISS_SAT  = '1;
  localparam logic [INDEX_W-1:0] INDEX_SAT = '1;

  // Position of the index count within its triangle
  typedef enum logic [1:0] {
    PHASE_0 = 2'd0,
    PHASE_1 = 2'd1,
    PHASE_2 = 2'd2
  } phase_t;

  typedef logic [VERTEX_W-1:0] vertex_t;

  // Control that every cell and the counters see
  typedef struct packed {
    logic advance;  // a transaction is taken this cycle
    logic flush;    // the transaction closes the buffer
  } step_ctl_t;

  // Counter values that go with the transaction being taken
  typedef struct packed {
    logic [MISS_W-1:0] miss_count;
    logic [TRI_W-1:0]  triangle_count;
    logic              bad_length;
  } count_t;

endpackage

// ----- src/lvcmc_cell.sv -----
// ----------------------------------------------------------------------------
// lvcmc_cell
// One cache entry: compares against the lookup and takes its neighbour's entry
// when everything in front of it moves down one place.
// ----------------------------------------------------------------------------
module lvcmc_cell
  import lvcmc_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  step_ctl_t ctl,
  input  vertex_t   lookup,
  input  logic      in_use,      // position lies below the cache size
  input  vertex_t   prev_entry,
  input  logic      prev_valid,
  input  logic      found_in,    // match in a cell nearer the front
  output vertex_t   entry_out,
  output logic      valid_out,
  output logic      found_out
);

  vertex_t entry;
  logic    valid;
  logic    valid_eff;
  logic    shift;

  // Positions beyond the size count as empty
  assign valid_eff = valid && in_use;
  assign found_out = found_in || (valid_eff && (entry == lookup));
  // Move down when the hit or the insertion point lies at or behind this cell
  assign shift     = !found_in && in_use && prev_valid;

  assign entry_out = entry;
  assign valid_out = valid_eff;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (ctl.advance) begin
      valid <= ctl.flush ? 1'b0 : (shift || valid_eff);
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.advance && shift) begin
      entry <= prev_entry;
    end
  end

endmodule

// ----- src/lvcmc_counters.sv -----
// ----------------------------------------------------------------------------
// lvcmc_counters
// Saturating miss and index counts, with the triangle count and its phase
// kept alongside so no divide by three is needed.
// ----------------------------------------------------------------------------
module lvcmc_counters
  import lvcmc_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  step_ctl_t ctl,
  input  logic      miss,
  output count_t    counts      // values including the current transaction
);

  logic [MISS_W-1:0]  miss_total;
  logic [INDEX_W-1:0] index_total;
  logic [TRI_W-1:0]   tri_total;
  phase_t             phase;

  logic [MISS_W-1:0]  miss_total_next;
  logic [INDEX_W-1:0] index_total_next;
  logic [TRI_W-1:0]   tri_total_next;
  phase_t             phase_next;

  always_comb begin
    miss_total_next = miss_total;
    if (miss && (miss_total != MISS_SAT)) begin
      miss_total_next = miss_total + MISS_W'(1);
    end

    index_total_next = index_total;
    tri_total_next   = tri_total;
    phase_next       = phase;
    // Hold the index count, triangle count and phase once the index count saturates (a whole triangle count)
    if (index_total != INDEX_SAT) begin
      index_total_next = index_total + INDEX_W'(1);
      case (phase)
        PHASE_0: phase_next = PHASE_1;
        PHASE_1: phase_next = PHASE_2;
        PHASE_2: begin
          phase_next     = PHASE_0;
          tri_total_next = tri_total + TRI_W'(1);
        end
        default: phase_next = PHASE_0;
      endcase
    end
  end

  assign counts.miss_count     = miss_total_next;
  assign counts.triangle_count = tri_total_next;
  assign counts.bad_length     = ctl.flush && (phase_next != PHASE_0);

  always_ff @(posedge clk) begin
    if (rst) begin
      miss_total  <= '0;
      index_total <= '0;
      tri_total   <= '0;
      phase       <= PHASE_0;
    end else if (ctl.advance) begin
      if (ctl.flush) begin
        miss_total  <= '0;
        index_total <= '0;
        tri_total   <= '0;
        phase       <= PHASE_0;
      end else begin
        miss_total  <= miss_total_next;
        index_total <= index_total_next;
        tri_total   <= tri_total_next;
        phase       <= phase_next;
      end
    end
  end

endmodule

// ----- src/lru_vertex_cache_miss_counter.sv -----
// ----------------------------------------------------------------------------
// lru_vertex_cache_miss_counter
// Fully associative LRU post-transform vertex cache model with miss and
// triangle counting over one index buffer at a time.
//
// Input channel: vertex_index and last_index, taken when in_valid and in_ready
// are both high. Output channel: was_hit, miss_count, triangle_count,
// end_of_buffer and bad_length, taken when out_valid and out_ready are high.
// Each input transaction yields exactly one output transaction.
//
// The lookup runs through the cell chain in the cycle
// the transaction is taken and the result lands in the output register.
// Throughput is one transaction per cycle, set by the single output register;
// in_ready drops only while a result is held and the receiver stalls.
//
// The cache is a chain of MAX_ENTRIES cells, most recent at the front. Every
// cell compares in parallel; on a hit or a miss the cells up to the hit (or
// insertion) point, that cell included, take their neighbour's entry and the
// index enters at the front. Positions at or beyond cache_size count as empty.
//
// Reset empties the cache, clears the counts and sets cache_size to 32.
// The transaction marked last_index closes the buffer: its result carries
// the final counts, then the cache and counts are cleared. Write cache_size
// only while the block is idle; zero acts as one entry.
// ----------------------------------------------------------------------------
module lru_vertex_cache_miss_counter
  import lvcmc_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  // configuration
  input  logic               cfg_we,
  input  logic [CFG_W-1:0]   cfg_wdata,
  // input channel
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [31:0]        vertex_index,
  input  logic               last_index,
  // output channel
  output logic               out_valid,
  input  logic               out_ready,
  output logic               was_hit,
  output logic [MISS_W-1:0]  miss_count,
  output logic [TRI_W-1:0]   triangle_count,
  output logic               end_of_buffer,
  output logic               bad_length
);

  logic [CFG_W-1:0] cache_size;
  logic [CMP_W-1:0] size_ext;
  logic [CMP_W-1:0] size_eff;

  step_ctl_t ctl;
  count_t    counts;
  logic      hit;

  logic [MAX_ENTRIES-1:0] in_use;
  vertex_t                entry_chain [MAX_ENTRIES+1];
  logic [MAX_ENTRIES:0]   valid_chain;
  logic [MAX_ENTRIES:0]   found_chain;

  // Configuration register
  always_ff @(posedge clk) begin
    if (rst) begin
      cache_size <= CACHE_SIZE_RESET;
    end else if (cfg_we) begin
      cache_size <= cfg_wdata;
    end
  end

  // Clamp the size to one at the bottom and to the built depth at the top
  assign size_ext = CMP_W'(cache_size);
  always_comb begin
    if (cache_size == '0) begin
      size_eff = CMP_W'(1);
    end else if (size_ext > CMP_W'(MAX_ENTRIES)) begin
      size_eff = CMP_W'(MAX_ENTRIES);
    end else begin
      size_eff = size_ext;
    end
  end

  always_comb begin
    for (int i = 0; i < MAX_ENTRIES; i++) begin
      in_use[i] = CMP_W'(i) < size_eff;
    end
  end

  // Take a new transaction whenever the output register is free or draining
  assign in_ready    = !out_valid || out_ready;
  assign ctl.advance = in_valid && in_ready;
  assign ctl.flush   = last_index;

  // Front of the chain: the new index, always valid, no match ahead of it
  assign entry_chain[0] = vertex_index;
  assign valid_chain[0] = 1'b1;
  assign found_chain[0] = 1'b0;

  for (genvar g = 0; g < MAX_ENTRIES; g++) begin : g_cell
    lvcmc_cell u_cell (
      .clk        (clk),
      .rst        (rst),
      .ctl        (ctl),
      .lookup     (vertex_index),
      .in_use     (in_use[g]),
      .prev_entry (entry_chain[g]),
      .prev_valid (valid_chain[g]),
      .found_in   (found_chain[g]),
      .entry_out  (entry_chain[g+1]),
      .valid_out  (valid_chain[g+1]),
      .found_out  (found_chain[g+1])
    );
  end

  // The entry in the last cell in use is dropped on a miss with the cache full
  assign hit = found_chain[MAX_ENTRIES];

  lvcmc_counters u_counters (
    .clk    (clk),
    .rst    (rst),
    .ctl    (ctl),
    .miss   (!hit),
    .counts (counts)
  );

  // Output register: hold while the receiver stalls, load on each transaction
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (ctl.advance) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.advance) begin
      was_hit        <= hit;
      miss_count     <= counts.miss_count;
      triangle_count <= counts.triangle_count;
      end_of_buffer  <= last_index;
      bad_length     <= counts.bad_length;
    end
  end

endmodule

// ----- src/lvcmc_checker.sv -----
// ----------------------------------------------------------------------------
// lvcmc_checker
// Port-level checks on the LRU vertex cache miss counter.
// ----------------------------------------------------------------------------
module lvcmc_checker
  import lvcmc_pkg::*;
(
  input logic              clk,
  input logic              rst,
  input logic              in_ready,
  input logic              out_valid,
  input logic              out_ready,
  input logic              was_hit,
  input logic [MISS_W-1:0] miss_count,
  input logic [TRI_W-1:0]  triangle_count,
  input logic              end_of_buffer,
  input logic              bad_length
);

  // Stalled result holds its payload
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(miss_count)
      && $stable(triangle_count) && $stable(was_hit))
    else $error("output transaction changed while stalled");

  // No new transaction while a result is stuck
  a_backpressure: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |-> !in_ready)
    else $error("input taken while output stalled");

  a_bad_len_end: assert property (@(posedge clk) disable iff (rst)
    out_valid && !end_of_buffer |-> !bad_length)
    else $error("length flag outside buffer end");

  // A hit needs an earlier miss in the same buffer
  a_hit_after_miss: assert property (@(posedge clk) disable iff (rst)
    out_valid && was_hit |-> miss_count != '0)
    else $error("hit reported with no miss in buffer");

  // Fewer than three indices cannot miss more than twice
  a_miss_bound: assert property (@(posedge clk) disable iff (rst)
    out_valid && (triangle_count == '0) |-> miss_count <= MISS_W'(2))
    else $error("miss count exceeds index count");

endmodule

bind lru_vertex_cache_miss_counter lvcmc_checker u_lvcmc_checker (
  .clk            (clk),
  .rst            (rst),
  .in_ready       (in_ready),
  .out_valid      (out_valid),
  .out_ready      (out_ready),
  .was_hit        (was_hit),
  .miss_count     (miss_count),
  .triangle_count (triangle_count),
  .end_of_buffer  (end_of_buffer),
  .bad_length     (bad_length)
);

// ----- dv/lvcmc_result_check.sv -----
// ----------------------------------------------------------------------------
// lvcmc_result_check
// Watches both channels and the size register of the LRU vertex cache miss
// counter. Keeps its own cache and counters, predicts each result and
// compares it with the one the block hands over.
// ----------------------------------------------------------------------------
module lvcmc_result_check
  import lvcmc_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              cfg_we,
  input  logic [CFG_W-1:0]  cfg_wdata,
  input  logic              in_valid,
  input  logic              in_ready,
  input  vertex_t           vertex_index,
  input  logic              last_index,
  input  logic              out_valid,
  input  logic              out_ready,
  input  logic              was_hit,
  input  logic [MISS_W-1:0] miss_count,
  input  logic [TRI_W-1:0]  triangle_count,
  input  logic              end_of_buffer,
  input  logic              bad_length,
  output int                fail_count,
  output int                pending_count,
  output int                result_count,
  output int                hit_count,
  output int                buffer_count,
  output int                bad_length_count
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int VERTS_PER_TRI = 3;

  typedef struct packed {
    logic              hit;
    logic [MISS_W-1:0] misses;
    logic [TRI_W-1:0]  triangles;
    logic              closes;
    logic              short_tail;
  } lookup_result_t;

  vertex_t            lru_cells [MAX_ENTRIES];
  int                 cells_used;
  logic [MISS_W-1:0]  buffer_misses;
  logic [INDEX_W-1:0] buffer_indices;
  logic [CFG_W-1:0]   size_setting;
  lookup_result_t     expected_lookups [$];
  int fails, results, hits, buffers, bad_lengths;

  // Look one index up, update the cache and counters, return the result
  function automatic lookup_result_t predict_lookup(input vertex_t v, input logic last);
    int limit;
    int hit_pos;
    int shift_from;
    lookup_result_t r;
    limit = (size_setting == 0) ? 1 :
            ((size_setting > MAX_ENTRIES) ? MAX_ENTRIES : int'(size_setting));
    // a smaller size drops the tail before the lookup
    if (cells_used > limit) cells_used = limit;
    hit_pos = -1;
    for (int i = 0; i < cells_used; i++)
      if (hit_pos < 0 && lru_cells[i] == v) hit_pos = i;
    if (hit_pos >= 0) begin
      shift_from = hit_pos;
    end else begin
      shift_from = (cells_used < limit) ? cells_used : limit - 1;
      if (cells_used < limit) cells_used++;
      if (buffer_misses != MISS_SAT) buffer_misses++;
    end
    for (int i = shift_from; i > 0; i--) lru_cells[i] = lru_cells[i-1];
    lru_cells[0] = v;
    if (buffer_indices != INDEX_SAT) buffer_indices++;
    r.hit        = (hit_pos >= 0);
    r.misses     = buffer_misses;
    r.triangles  = TRI_W'(buffer_indices / VERTS_PER_TRI);
    r.closes     = last;
    r.short_tail = last && (buffer_indices % VERTS_PER_TRI != 0);
    if (last) begin
      cells_used     = 0;
      buffer_misses  = '0;
      buffer_indices = '0;
    end
    return r;
  endfunction

  always @(posedge clk) begin
    lookup_result_t got;
    lookup_result_t want;
    lookup_result_t next_lookup;
    if (rst) begin
      cells_used     = 0;
      buffer_misses  = '0;
      buffer_indices = '0;
      size_setting   = CACHE_SIZE_RESET;
      expected_lookups.delete();
    end else begin
      // retire the result first: it can never belong to this edge's input
      if (out_valid && out_ready) begin
        got = {was_hit, miss_count, triangle_count, end_of_buffer, bad_length};
        results++;
        if (got.hit) hits++;
        if (got.closes) buffers++;
        if (got.short_tail) bad_lengths++;
        if (expected_lookups.size() == 0) begin
          fails++;
          $display({"%0t: result %0d arrived with nothing expected, got hit=%0b ",
                    "misses=%0d triangles=%0d last=%0b bad=%0b"}, $time, results,
                   got.hit, got.misses, got.triangles, got.closes, got.short_tail);
        end else begin
          want = expected_lookups.pop_front();
          if (got !== want) begin
            fails++;
            $display({"%0t: result %0d expected hit=%0b misses=%0d triangles=%0d ",
                      "last=%0b bad=%0b, got hit=%0b misses=%0d triangles=%0d ",
                      "last=%0b bad=%0b"}, $time, results,
                     want.hit, want.misses, want.triangles, want.closes,
                     want.short_tail, got.hit, got.misses, got.triangles,
                     got.closes, got.short_tail);
          end
        end
      end
      if (in_valid && in_ready) begin
        next_lookup      = predict_lookup(vertex_index, last_index);
        expected_lookups = {expected_lookups, next_lookup};
      end
      // the block takes the new size at this edge; items after it use it
      if (cfg_we) size_setting = cfg_wdata;
    end
    fail_count       <= fails;
    pending_count    <= expected_lookups.size();
    result_count     <= results;
    hit_count        <= hits;
    buffer_count     <= buffers;
    bad_length_count <= bad_lengths;
  end

endmodule

// ----- dv/lru_vertex_cache_miss_counter_test.sv -----
// ----------------------------------------------------------------------------
// lru_vertex_cache_miss_counter_test
// Stimulus and verdict for the LRU vertex cache miss counter. Directed index
// buffers cover the extreme indices, short and odd buffer lengths and the
// size corner cases; random triangle lists over small vertex pools follow,
// under changing cache sizes and random gaps on both channels. Checking is
// done by lvcmc_result_check, which sits beside the block.
// ----------------------------------------------------------------------------
module lru_vertex_cache_miss_counter_test;
  import lvcmc_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int RANDOM_ITEMS   = 1150;
  localparam int WATCHDOG_LIMIT = 1000;
  localparam int POOL_DEPTH     = 48;

  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic              cfg_we = 1'b0;
  logic [CFG_W-1:0]  cfg_wdata = '0;
  logic              in_valid = 1'b0;
  logic              in_ready;
  vertex_t           vertex_index = '0;
  logic              last_index = 1'b0;
  logic              out_valid;
  logic              out_ready = 1'b0;
  logic              was_hit;
  logic [MISS_W-1:0] miss_count;
  logic [TRI_W-1:0]  triangle_count;
  logic              end_of_buffer;
  logic              bad_length;

  int fail_count, pending_count, result_count, hit_count, buffer_count, bad_length_count;

  // When set, neither side leaves gaps
  logic free_run = 1'b0;
  int   ready_hold = 0;
  int   idle_cycles = 0;
  int   size_writes = 0;

  // Random triangle-list generator state
  vertex_t vertex_pool [POOL_DEPTH];
  int      pool_used = 1;
  int      buffer_length = 0;
  int      buffer_fill = 0;

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  lru_vertex_cache_miss_counter dut (
    .clk            (clk),
    .rst            (rst),
    .cfg_we         (cfg_we),
    .cfg_wdata      (cfg_wdata),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .vertex_index   (vertex_index),
    .last_index     (last_index),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .was_hit        (was_hit),
    .miss_count     (miss_count),
    .triangle_count (triangle_count),
    .end_of_buffer  (end_of_buffer),
    .bad_length     (bad_length)
  );

  lvcmc_result_check result_check (
    .clk              (clk),
    .rst              (rst),
    .cfg_we           (cfg_we),
    .cfg_wdata        (cfg_wdata),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .vertex_index     (vertex_index),
    .last_index       (last_index),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .was_hit          (was_hit),
    .miss_count       (miss_count),
    .triangle_count   (triangle_count),
    .end_of_buffer    (end_of_buffer),
    .bad_length       (bad_length),
    .fail_count       (fail_count),
    .pending_count    (pending_count),
    .result_count     (result_count),
    .hit_count        (hit_count),
    .buffer_count     (buffer_count),
    .bad_length_count (bad_length_count)
  );

  // Gap length: mostly none, sometimes a short one, now and then a long one
  function automatic int idle_gap();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 60) return 0;
    if (roll < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Cache size to program: the corners often, anything now and then
  function automatic logic [CFG_W-1:0] pick_size();
    case ($urandom_range(0, 11))
      0:       return '0;
      1:       return CFG_W'(1);
      2:       return CFG_W'(2);
      3:       return CFG_W'(3);
      4:       return CFG_W'(4);
      5:       return CFG_W'(8);
      6:       return CFG_W'(16);
      7:       return CFG_W'(31);
      8, 9:    return CFG_W'(MAX_ENTRIES);
      10:      return '1;
      default: return CFG_W'($urandom_range(0, 63));
    endcase
  endfunction

  // Receiver: hold out_ready low for a random stall, then raise it again
  always @(posedge clk) begin
    if (ready_hold > 0) begin
      out_ready <= 1'b0;
      ready_hold--;
    end else begin
      out_ready <= 1'b1;
      ready_hold = free_run ? 0 : idle_gap();
    end
  end

  // Watchdog: end the run if nothing moves on either channel for too long
  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles + 1 >= WATCHDOG_LIMIT) begin
      $display("%0t: no transaction for %0d cycles", $time, WATCHDOG_LIMIT);
      $display("[lru_vertex_cache_miss_counter] ERROR");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // Present one index after an optional gap and hold it until it is taken
  task automatic send_vertex(input vertex_t v, input logic last);
    int gap;
    gap = free_run ? 0 : idle_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid     <= 1'b1;
    vertex_index <= v;
    last_index   <= last;
    do @(posedge clk); while (!in_ready);
  endtask

  // Stop sending and wait until every result is back, then a little longer
  task automatic drain();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending_count != 0);
    repeat (2) @(posedge clk);
  endtask

  // Change the cache size with the block idle
  task automatic write_size(input logic [CFG_W-1:0] size);
    drain();
    cfg_we    <= 1'b1;
    cfg_wdata <= size;
    @(posedge clk);
    cfg_we    <= 1'b0;
    size_writes++;
  endtask

  // New buffer: a small vertex pool mixing runs of neighbours and scattered
  // values, and a length that is usually whole triangles
  task automatic start_buffer();
    vertex_t base;
    base      = $urandom;
    pool_used = $urandom_range(2, POOL_DEPTH);
    for (int i = 0; i < pool_used; i++)
      vertex_pool[i] = ($urandom_range(0, 1) != 0) ? base + vertex_t'(i) : vertex_t'($urandom);
    buffer_length = ($urandom_range(0, 4) != 0) ? 3 * $urandom_range(1, 40)
                                                : $urandom_range(1, 100);
    buffer_fill = 0;
  endtask

  initial begin : stimulus
    vertex_t v;
    int      phase_items;
    int      random_sent;
    random_sent = 0;

    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // Directed part, reset size of 32 first.
    // Extreme indices with hits on both, odd length of four.
    send_vertex('0, 1'b0);
    send_vertex('1, 1'b0);
    send_vertex('0, 1'b0);
    send_vertex('1, 1'b1);
    // One whole triangle, then two indices, then a buffer of one index.
    send_vertex(vertex_t'(1), 1'b0);
    send_vertex(vertex_t'(2), 1'b0);
    send_vertex(vertex_t'(1), 1'b1);
    send_vertex(vertex_t'(9), 1'b0);
    send_vertex(vertex_t'(9), 1'b1);
    send_vertex(vertex_t'(7), 1'b1);
    // Size zero behaves as a single entry: 6 evicts 5.
    write_size('0);
    send_vertex(vertex_t'(5), 1'b0);
    send_vertex(vertex_t'(5), 1'b0);
    send_vertex(vertex_t'(6), 1'b0);
    send_vertex(vertex_t'(5), 1'b1);
    // Shrink mid-buffer: 12 falls beyond the new size and misses again.
    write_size(CFG_W'(MAX_ENTRIES));
    for (int i = 10; i <= 14; i++) send_vertex(vertex_t'(i), 1'b0);
    write_size(CFG_W'(2));
    send_vertex(vertex_t'(12), 1'b0);
    send_vertex(vertex_t'(14), 1'b1);
    // A size above the built depth saturates.
    write_size('1);
    send_vertex(vertex_t'(20), 1'b0);
    send_vertex(vertex_t'(20), 1'b1);

    // Random part: phases of triangle lists, each maybe under a new size.
    // A phase can end mid-buffer, so size changes land inside buffers too.
    while (random_sent < RANDOM_ITEMS) begin
      if ($urandom_range(0, 9) < 7) write_size(pick_size());
      else if ($urandom_range(0, 3) == 0) drain();
      free_run <= ($urandom_range(0, 5) == 0);
      phase_items = $urandom_range(20, 150);
      repeat (phase_items) begin
        if (buffer_fill == buffer_length) start_buffer();
        // now and then an index from anywhere in the range
        v = ($urandom_range(0, 9) == 0) ? vertex_t'($urandom)
                                        : vertex_pool[$urandom_range(0, pool_used - 1)];
        buffer_fill++;
        send_vertex(v, buffer_fill == buffer_length);
        random_sent++;
      end
    end

    // Let the last results come back and check nothing extra follows
    drain();
    repeat (4) @(posedge clk);
    $display("Run covered %0d results: %0d hits, %0d misses, %0d buffers closed",
             result_count, hit_count, result_count - hit_count, buffer_count);
    $display("of which %0d had a bad length; cache size was set %0d times",
             bad_length_count, size_writes);
    if (fail_count == 0 && pending_count == 0) begin
      $display("[lru_vertex_cache_miss_counter] OK");
    end else begin
      $display("[lru_vertex_cache_miss_counter] ERROR");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
src/lvcmc_pkg.sv
src/lvcmc_cell.sv
src/lvcmc_counters.sv
src/lru_vertex_cache_miss_counter.sv
src/lvcmc_checker.sv
dv/lvcmc_result_check.sv
dv/lru_vertex_cache_miss_counter_test.sv
